[hw/rtl/surface_exchange_link_kernel_assert.svh]
// assertion macros used by the link kernel controller
`ifndef SURFACE_EXCHANGE_LINK_KERNEL_ASSERT_SVH
`define SURFACE_EXCHANGE_LINK_KERNEL_ASSERT_SVH

// property checked on every clock edge outside reset
`define SELK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication outside reset
`define SELK_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication outside reset
`define SELK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/selk_pkg.sv]
// shared types, step codes and micro-op table of the link kernel
package selk_pkg;

    localparam int STEP_BITS = 5;

    localparam logic [STEP_BITS-1:0] ST_FIRST    = 5'd0;
    localparam logic [STEP_BITS-1:0] ST_CELL     = 5'd9;
    localparam logic [STEP_BITS-1:0] ST_CELL_END = 5'd17;
    localparam logic [STEP_BITS-1:0] ST_ET       = 5'd18;

    // operand sources
    localparam logic [4:0] SRC_S12 = 5'd0;
    localparam logic [4:0] SRC_NSQ = 5'd1;
    localparam logic [4:0] SRC_W   = 5'd2;
    localparam logic [4:0] SRC_C2  = 5'd3;
    localparam logic [4:0] SRC_T   = 5'd4;
    localparam logic [4:0] SRC_X   = 5'd5;
    localparam logic [4:0] SRC_G   = 5'd6;
    localparam logic [4:0] SRC_K   = 5'd7;
    localparam logic [4:0] SRC_HC  = 5'd8;
    localparam logic [4:0] SRC_D0  = 5'd9;
    localparam logic [4:0] SRC_D1  = 5'd10;
    localparam logic [4:0] SRC_D2  = 5'd11;
    localparam logic [4:0] SRC_MV0 = 5'd12;
    localparam logic [4:0] SRC_MV1 = 5'd13;
    localparam logic [4:0] SRC_MV2 = 5'd14;
    localparam logic [4:0] SRC_INV = 5'd15;
    localparam logic [4:0] SRC_S0  = 5'd16;
    localparam logic [4:0] SRC_S1  = 5'd17;
    localparam logic [4:0] SRC_S2  = 5'd18;
    localparam logic [4:0] SRC_H0  = 5'd19;
    localparam logic [4:0] SRC_H1  = 5'd20;
    localparam logic [4:0] SRC_H2  = 5'd21;
    localparam logic [4:0] SRC_ACC = 5'd22;
    localparam logic [4:0] SRC_V2  = 5'd23;
    localparam int         NUM_SRC = 24;

    // destinations
    localparam logic [3:0] DST_C1  = 4'd0;
    localparam logic [3:0] DST_C2  = 4'd1;
    localparam logic [3:0] DST_X   = 4'd2;
    localparam logic [3:0] DST_E   = 4'd3;
    localparam logic [3:0] DST_G   = 4'd4;
    localparam logic [3:0] DST_K   = 4'd5;
    localparam logic [3:0] DST_MV0 = 4'd6;
    localparam logic [3:0] DST_MV1 = 4'd7;
    localparam logic [3:0] DST_MV2 = 4'd8;
    localparam logic [3:0] DST_H0  = 4'd9;
    localparam logic [3:0] DST_H1  = 4'd10;
    localparam logic [3:0] DST_H2  = 4'd11;
    localparam logic [3:0] DST_T0  = 4'd12;
    localparam logic [3:0] DST_T1  = 4'd13;
    localparam logic [3:0] DST_T2  = 4'd14;
    localparam logic [3:0] DST_ET  = 4'd15;

    // write modes
    localparam logic [1:0] MD_SET   = 2'd0;
    localparam logic [1:0] MD_ADDC1 = 2'd1;
    localparam logic [1:0] MD_SUB   = 2'd2;

    // shift codes
    localparam logic [2:0] SH8  = 3'd0;
    localparam logic [2:0] SH15 = 3'd1;
    localparam logic [2:0] SH16 = 3'd2;
    localparam logic [2:0] SH29 = 3'd3;
    localparam logic [2:0] SH30 = 3'd4;

    // saturation limits
    localparam logic [1:0] LM62 = 2'd0;
    localparam logic [1:0] LM48 = 2'd1;
    localparam logic [1:0] LM63 = 2'd2;

    localparam logic [63:0] LIM62 = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM48 = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] LIM63 = 64'h7FFF_FFFF_FFFF_FFFF;

    // 2/mu0 with 8 fraction bits
    localparam logic signed [63:0] HCOEF_Q8 = 64'sd407436654;

    typedef struct packed {
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [2:0] shf;
        logic [1:0] lim;
        logic [3:0] dst;
        logic [1:0] mode;
    } uop_t;

    typedef struct packed {
        logic                 load;
        logic                 dot_en;
        logic [1:0]           dsel;
        logic                 max_upd;
        logic                 mul_start;
        logic                 mul_wr;
        logic [STEP_BITS-1:0] step;
        logic                 side_b;
        logic                 emit;
    } selk_cmd_t;

    typedef struct packed {
        logic skip;
        logic fin;
        logic mul_done;
        logic out_free;
    } selk_sts_t;

    function automatic uop_t uop_of(input logic [STEP_BITS-1:0] step);
        uop_t u;
        u = '{SRC_S12, SRC_W, SH8, LM62, DST_C1, MD_SET};
        case (step)
            5'd0:  u = '{SRC_S12, SRC_W,   SH8,  LM62, DST_C1,  MD_SET};
            5'd1:  u = '{SRC_NSQ, SRC_W,   SH8,  LM62, DST_C2,  MD_SET};
            5'd2:  u = '{SRC_C2,  SRC_T,   SH30, LM62, DST_X,   MD_ADDC1};
            5'd3:  u = '{SRC_X,   SRC_T,   SH30, LM48, DST_E,   MD_SET};
            5'd4:  u = '{SRC_C2,  SRC_T,   SH29, LM62, DST_G,   MD_ADDC1};
            5'd5:  u = '{SRC_G,   SRC_HC,  SH8,  LM62, DST_K,   MD_SET};
            5'd6:  u = '{SRC_D0,  SRC_K,   SH15, LM62, DST_MV0, MD_SET};
            5'd7:  u = '{SRC_D1,  SRC_K,   SH15, LM62, DST_MV1, MD_SET};
            5'd8:  u = '{SRC_D2,  SRC_K,   SH15, LM62, DST_MV2, MD_SET};
            5'd9:  u = '{SRC_MV0, SRC_INV, SH16, LM48, DST_H0,  MD_SET};
            5'd10: u = '{SRC_MV1, SRC_INV, SH16, LM48, DST_H1,  MD_SET};
            5'd11: u = '{SRC_MV2, SRC_INV, SH16, LM48, DST_H2,  MD_SET};
            5'd12: u = '{SRC_S1,  SRC_H2,  SH15, LM62, DST_T0,  MD_SET};
            5'd13: u = '{SRC_S2,  SRC_H1,  SH15, LM62, DST_T0,  MD_SUB};
            5'd14: u = '{SRC_S2,  SRC_H0,  SH15, LM62, DST_T1,  MD_SET};
            5'd15: u = '{SRC_S0,  SRC_H2,  SH15, LM62, DST_T1,  MD_SUB};
            5'd16: u = '{SRC_S0,  SRC_H1,  SH15, LM62, DST_T2,  MD_SET};
            5'd17: u = '{SRC_S1,  SRC_H0,  SH15, LM62, DST_T2,  MD_SUB};
            5'd18: u = '{SRC_ACC, SRC_V2,  SH16, LM63, DST_ET,  MD_SET};
            default: u = '{SRC_S12, SRC_W, SH8, LM62, DST_C1, MD_SET};
        endcase
        return u;
    endfunction

endpackage

[hw/rtl/selk_mul.sv]
// iterative signed multiply with magnitude shift and symmetric saturation
module selk_mul
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    input  logic [2:0]         shf,
    input  logic [1:0]         lim,
    output logic               done,
    output logic signed [63:0] res
);

    logic         busy_reg, busy_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic         done_reg, done_next;
    logic [63:0]  ma_reg, ma_next;
    logic [63:0]  mb_reg, mb_next;
    logic         neg_reg, neg_next;
    logic [2:0]   shf_reg, shf_next;
    logic [1:0]   lim_reg, lim_next;
    logic [127:0] prod_reg, prod_next;
    logic signed [63:0] res_reg, res_next;

    logic [63:0]  pp;
    logic [127:0] pp_ext;
    logic [127:0] shifted;
    logic [63:0]  limv;
    logic [63:0]  mag_r;

    always_comb
    begin
        pp = ma_reg[{cnt_reg[1], 5'd0} +: 32] * mb_reg[{cnt_reg[0], 5'd0} +: 32];
        case ({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]})
            2'd0:    pp_ext = {64'd0, pp};
            2'd1:    pp_ext = {32'd0, pp, 32'd0};
            default: pp_ext = {pp, 64'd0};
        endcase
        case (shf_reg)
            selk_pkg::SH8:  shifted = prod_reg >> 8;
            selk_pkg::SH15: shifted = prod_reg >> 15;
            selk_pkg::SH16: shifted = prod_reg >> 16;
            selk_pkg::SH29: shifted = prod_reg >> 29;
            selk_pkg::SH30: shifted = prod_reg >> 30;
            default:        shifted = prod_reg;
        endcase
        case (lim_reg)
            selk_pkg::LM48: limv = selk_pkg::LIM48;
            selk_pkg::LM63: limv = selk_pkg::LIM63;
            default:        limv = selk_pkg::LIM62;
        endcase
        if ((shifted[127:64] != 64'd0) || (shifted[63:0] > limv))
        begin
            mag_r = limv;
        end
        else
        begin
            mag_r = shifted[63:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        shf_next  = shf_reg;
        lim_next  = lim_reg;
        prod_next = prod_reg;
        res_next  = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            ma_next   = a[63] ? 64'(-a) : 64'(a);
            mb_next   = b[63] ? 64'(-b) : 64'(b);
            neg_next  = a[63] ^ b[63];
            shf_next  = shf;
            lim_next  = lim;
            prod_next = 128'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 3'd4)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? -$signed(mag_r) : $signed(mag_r);
            end
            else
            begin
                prod_next = prod_reg + pp_ext;
                cnt_next  = cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        neg_reg  <= neg_next;
        shf_reg  <= shf_next;
        lim_reg  <= lim_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

[hw/rtl/selk_datapath.sv]
// datapath: config registers, link operands, pass totals and output register
module selk_datapath #(
    parameter int CELL_INDEX_BITS = 24
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic [1:0]               cfg_index,
    input  logic [31:0]              cfg_data,
    input  logic [((2*CELL_INDEX_BITS+176+7)/8)*8-1:0] in_data,
    input  logic                     in_last,
    input  selk_pkg::selk_cmd_t      cmd,
    output selk_pkg::selk_sts_t      sts,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [((CELL_INDEX_BITS+432+7)/8)*8-1:0] out_data,
    output logic                     out_user,
    output logic                     out_last
);

    localparam int CB    = CELL_INDEX_BITS;
    localparam int OUT_W = ((CB + 432 + 7) / 8) * 8;
    localparam int SB    = 2 * CB;

    localparam logic [1:0] REG_SIG_BL = 2'd0;
    localparam logic [1:0] REG_SIG_BQ = 2'd1;
    localparam logic [1:0] REG_CVOL   = 2'd2;

    logic signed [31:0] sig_bl_reg, sig_bq_reg;
    logic [31:0]        cvol_reg;

    logic [CB-1:0]      idx_a_reg, idx_b_reg;
    logic signed [15:0] sa_reg [0:2];
    logic signed [15:0] sb_reg [0:2];
    logic [31:0]        inv_a_reg, inv_b_reg;
    logic [15:0]        w_reg;
    logic               fin_reg, skip_reg;

    logic [33:0]        dot_reg;
    logic [31:0]        max_reg;
    logic signed [63:0] acc_reg;

    logic signed [63:0] c1_reg, c2_reg, x_reg, e_reg, g_reg, k_reg, et_reg;
    logic signed [63:0] mv_reg [0:2];
    logic signed [63:0] h_reg  [0:2];
    logic signed [63:0] tq_reg [0:2];

    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;
    logic               out_user_reg, out_user_next;
    logic               out_last_reg, out_last_next;

    selk_pkg::uop_t     u;
    logic signed [63:0] opnd [0:selk_pkg::NUM_SRC-1];
    logic signed [16:0] d [0:2];
    logic signed [16:0] dsel_v;
    logic [33:0]        sq;
    logic [31:0]        dsat;
    logic signed [63:0] mul_res;
    logic               mul_done;
    logic signed [64:0] acc_sum;
    logic signed [63:0] acc_next;
    logic               last_now;
    logic               out_free;

    function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
        logic signed [63:0] lim;
        lim = $signed(selk_pkg::LIM48);
        if (v > lim)
        begin
            return lim[47:0];
        end
        else if (v < -lim)
        begin
            return 48'(-lim);
        end
        return v[47:0];
    endfunction

    assign u = selk_pkg::uop_of(cmd.step);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d[i] = 17'(sa_reg[i]) - 17'(sb_reg[i]);
        end
        case (cmd.dsel)
            2'd0:    dsel_v = d[0];
            2'd1:    dsel_v = d[1];
            default: dsel_v = d[2];
        endcase
        sq   = 34'($signed(dsel_v) * $signed(dsel_v));
        dsat = (dot_reg > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : dot_reg[31:0];
    end

    always_comb
    begin
        opnd[selk_pkg::SRC_S12] = 64'(sig_bl_reg) + (64'(sig_bq_reg) <<< 1);
        opnd[selk_pkg::SRC_NSQ] = -64'(sig_bq_reg);
        opnd[selk_pkg::SRC_W]   = $signed({48'd0, w_reg});
        opnd[selk_pkg::SRC_C2]  = c2_reg;
        opnd[selk_pkg::SRC_T]   = $signed({33'd0, dsat[31:1]});
        opnd[selk_pkg::SRC_X]   = x_reg;
        opnd[selk_pkg::SRC_G]   = g_reg;
        opnd[selk_pkg::SRC_K]   = k_reg;
        opnd[selk_pkg::SRC_HC]  = selk_pkg::HCOEF_Q8;
        opnd[selk_pkg::SRC_D0]  = 64'(d[0]);
        opnd[selk_pkg::SRC_D1]  = 64'(d[1]);
        opnd[selk_pkg::SRC_D2]  = 64'(d[2]);
        opnd[selk_pkg::SRC_MV0] = mv_reg[0];
        opnd[selk_pkg::SRC_MV1] = mv_reg[1];
        opnd[selk_pkg::SRC_MV2] = mv_reg[2];
        opnd[selk_pkg::SRC_INV] = cmd.side_b ? $signed({32'd0, inv_b_reg})
                                             : -$signed({32'd0, inv_a_reg});
        opnd[selk_pkg::SRC_S0]  = cmd.side_b ? 64'(sb_reg[0]) : 64'(sa_reg[0]);
        opnd[selk_pkg::SRC_S1]  = cmd.side_b ? 64'(sb_reg[1]) : 64'(sa_reg[1]);
        opnd[selk_pkg::SRC_S2]  = cmd.side_b ? 64'(sb_reg[2]) : 64'(sa_reg[2]);
        opnd[selk_pkg::SRC_H0]  = h_reg[0];
        opnd[selk_pkg::SRC_H1]  = h_reg[1];
        opnd[selk_pkg::SRC_H2]  = h_reg[2];
        opnd[selk_pkg::SRC_ACC] = acc_reg;
        opnd[selk_pkg::SRC_V2]  = $signed({31'd0, cvol_reg, 1'b0});
    end

    selk_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (opnd[u.src_a]),
        .b     (opnd[u.src_b]),
        .shf   (u.shf),
        .lim   (u.lim),
        .done  (mul_done),
        .res   (mul_res)
    );

    // saturating energy accumulation
    always_comb
    begin
        acc_sum = 65'(acc_reg) + 65'(mul_res);
        if (acc_sum > 65'sh0_7FFF_FFFF_FFFF_FFFF)
        begin
            acc_next = 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        else if (acc_sum < -65'sh0_8000_0000_0000_0000)
        begin
            acc_next = 64'sh8000_0000_0000_0000;
        end
        else
        begin
            acc_next = acc_sum[63:0];
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign last_now = skip_reg || cmd.side_b;

    // result formatting
    always_comb
    begin
        out_data_next = '0;
        out_user_next = 1'b0;
        out_last_next = last_now;
        if (!skip_reg)
        begin
            out_data_next[CB-1:0]      = cmd.side_b ? idx_b_reg : idx_a_reg;
            out_data_next[CB+47:CB]    = e_reg[47:0];
            out_data_next[CB+95:CB+48] = h_reg[0][47:0];
            out_data_next[CB+143:CB+96]  = h_reg[1][47:0];
            out_data_next[CB+191:CB+144] = h_reg[2][47:0];
            out_data_next[CB+239:CB+192] = clamp48(tq_reg[0]);
            out_data_next[CB+287:CB+240] = clamp48(tq_reg[1]);
            out_data_next[CB+335:CB+288] = clamp48(tq_reg[2]);
            out_user_next = 1'b1;
        end
        if (last_now && fin_reg)
        begin
            out_data_next[CB+399:CB+336] = et_reg;
            out_data_next[CB+431:CB+400] = max_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_bl_reg    <= '0;
            sig_bq_reg    <= '0;
            cvol_reg      <= '0;
            acc_reg       <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_SIG_BL: sig_bl_reg <= cfg_data;
                    REG_SIG_BQ: sig_bq_reg <= cfg_data;
                    REG_CVOL:   cvol_reg   <= cfg_data;
                    default:    ;
                endcase
            end
            if (cmd.mul_wr && (u.dst == selk_pkg::DST_E))
            begin
                acc_reg <= acc_next;
            end
            if (cmd.max_upd && (dsat > max_reg))
            begin
                max_reg <= dsat;
            end
            if (cmd.emit && last_now && fin_reg)
            begin
                acc_reg <= '0;
                max_reg <= '0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_a_reg <= in_data[CB-1:0];
            idx_b_reg <= in_data[SB-1:CB];
            for (int i = 0; i < 3; i++)
            begin
                sa_reg[i] <= in_data[SB+16*i +: 16];
                sb_reg[i] <= in_data[SB+48+16*i +: 16];
            end
            inv_a_reg <= in_data[SB+127:SB+96];
            inv_b_reg <= in_data[SB+159:SB+128];
            w_reg     <= in_data[SB+175:SB+160];
            fin_reg   <= in_last;
            skip_reg  <= (in_data[SB+127:SB+96] == 32'd0) || (in_data[SB+159:SB+128] == 32'd0);
            dot_reg   <= '0;
        end
        else if (cmd.dot_en)
        begin
            dot_reg <= dot_reg + sq;
        end
        if (cmd.mul_wr)
        begin
            case (u.dst)
                selk_pkg::DST_C1:  c1_reg <= mul_res;
                selk_pkg::DST_C2:  c2_reg <= mul_res;
                selk_pkg::DST_X:   x_reg  <= c1_reg + mul_res;
                selk_pkg::DST_E:   e_reg  <= mul_res;
                selk_pkg::DST_G:   g_reg  <= c1_reg + mul_res;
                selk_pkg::DST_K:   k_reg  <= mul_res;
                selk_pkg::DST_MV0: mv_reg[0] <= mul_res;
                selk_pkg::DST_MV1: mv_reg[1] <= mul_res;
                selk_pkg::DST_MV2: mv_reg[2] <= mul_res;
                selk_pkg::DST_H0:  h_reg[0] <= mul_res;
                selk_pkg::DST_H1:  h_reg[1] <= mul_res;
                selk_pkg::DST_H2:  h_reg[2] <= mul_res;
                selk_pkg::DST_T0:  tq_reg[0] <= (u.mode == selk_pkg::MD_SUB)
                                                ? tq_reg[0] - mul_res : mul_res;
                selk_pkg::DST_T1:  tq_reg[1] <= (u.mode == selk_pkg::MD_SUB)
                                                ? tq_reg[1] - mul_res : mul_res;
                selk_pkg::DST_T2:  tq_reg[2] <= (u.mode == selk_pkg::MD_SUB)
                                                ? tq_reg[2] - mul_res : mul_res;
                selk_pkg::DST_ET:  et_reg <= mul_res;
                default:           ;
            endcase
        end
        if (cmd.emit)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
            out_last_reg <= out_last_next;
        end
    end

    assign sts.skip     = skip_reg;
    assign sts.fin      = fin_reg;
    assign sts.mul_done = mul_done;
    assign sts.out_free = out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

endmodule

[hw/rtl/selk_ctrl.sv]
// controller: sequences dot product, micro-op steps and result requests
module selk_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  selk_pkg::selk_sts_t sts,
    output selk_pkg::selk_cmd_t cmd
);

    `include "surface_exchange_link_kernel_assert.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DOT   = 3'd1;
    localparam logic [2:0] S_MAX   = 3'd2;
    localparam logic [2:0] S_ISSUE = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [selk_pkg::STEP_BITS-1:0] step_reg, step_next;
    logic                           cell_reg, cell_next;
    logic [1:0]                     dcnt_reg, dcnt_next;
    logic                           first_reg, first_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cell_next  = cell_reg;
        dcnt_next  = dcnt_reg;
        first_next = 1'b0;
        cmd        = '0;
        cmd.step   = step_reg;
        cmd.side_b = cell_reg;
        cmd.dsel   = dcnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    dcnt_next  = 2'd0;
                    first_next = 1'b1;
                    state_next = S_DOT;
                end
            end
            S_DOT:
            begin
                if (first_reg && sts.skip)
                begin
                    if (sts.fin)
                    begin
                        step_next  = selk_pkg::ST_ET;
                        cell_next  = 1'b1;
                        state_next = S_ISSUE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.dot_en = 1'b1;
                    dcnt_next  = dcnt_reg + 2'd1;
                    if (dcnt_reg == 2'd2)
                    begin
                        state_next = S_MAX;
                    end
                end
            end
            S_MAX:
            begin
                cmd.max_upd = 1'b1;
                step_next   = selk_pkg::ST_FIRST;
                cell_next   = 1'b0;
                state_next  = S_ISSUE;
            end
            S_ISSUE:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.mul_wr = 1'b1;
                    if (step_reg == selk_pkg::ST_CELL_END)
                    begin
                        if (cell_reg && sts.fin)
                        begin
                            step_next  = selk_pkg::ST_ET;
                            state_next = S_ISSUE;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    else if (step_reg == selk_pkg::ST_ET)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        step_next  = step_reg + 5'd1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!sts.skip && !cell_reg)
                    begin
                        cell_next  = 1'b1;
                        step_next  = selk_pkg::ST_CELL;
                        state_next = S_ISSUE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            cell_reg  <= 1'b0;
            dcnt_reg  <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cell_reg  <= cell_next;
            dcnt_reg  <= dcnt_next;
            first_reg <= first_next;
        end
    end

    `SELK_ASSERT_IMPL(a_done_in_wait, sts.mul_done, state_reg == S_WAIT,
        "multiply finished outside wait state")
    `SELK_ASSERT_IMPL(a_step_range, state_reg == S_WAIT, step_reg <= selk_pkg::ST_ET,
        "step beyond micro-op table")
    `SELK_ASSERT_NEXT(a_last_to_idle,
        (state_reg == S_EMIT) && sts.out_free && (cell_reg || sts.skip),
        state_reg == S_IDLE, "no return to idle after last result")

endmodule

[hw/rtl/surface_exchange_link_kernel.sv]
// top level of the interlayer exchange link kernel
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata link fields, tlast final_link
// m_axis    out  m_axis_tvalid/tready       tdata cell result, tuser contributes,
//                                           tlast last_of_item
// cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// one link at a time; a shared 64x64 multiplier (four 32x32 partial products)
// computes 27 products per contributing link, plus one on a final link;
// a skipped link is dropped with no result, a skipped final link computes
// only the energy total
// asynchronous active-low reset clears state, totals and config registers
// a stalled m_axis holds the finished request; the next link is taken meanwhile
module surface_exchange_link_kernel #(
    parameter int CELL_INDEX_BITS = 24
)
(
    input  logic clk,
    input  logic rst_n,
    // cell_index_a, cell_index_b, spin_a_x/y/z, spin_b_x/y/z, inv_mag_a, inv_mag_b,
    // cell_weight, zero pad
    input  logic [((2*CELL_INDEX_BITS+176+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic s_axis_tlast,
    // cell_index, energy_density, field_x/y/z, torque_x/y/z, energy_total,
    // max_diff_sq, zero pad
    output logic [((CELL_INDEX_BITS+432+7)/8)*8-1:0] m_axis_tdata,
    // contributes
    output logic m_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic m_axis_tlast,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    selk_pkg::selk_cmd_t cmd;
    selk_pkg::selk_sts_t sts;
    logic                in_ready;

    assign s_axis_tready = in_ready;
    assign cfg_ready     = 1'b1;

    selk_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    selk_datapath #(
        .CELL_INDEX_BITS (CELL_INDEX_BITS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
